// ===== hdl/ten_pkg.sv =====
// Package for the triangle edge numbering block: types and constants.
package ten_pkg;

  localparam int unsigned NodeBitsDef = 16;
  localparam int unsigned MaxEdgesDef = 4096;
  localparam int unsigned NumW = 12;
  localparam int unsigned CntW = 13;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [15:0] node_c;
    logic        last_triangle;
  } in_word_t;

  typedef struct packed {
    logic [NumW-1:0] edge_opposite_a;
    logic [NumW-1:0] edge_opposite_b;
    logic [NumW-1:0] edge_opposite_c;
    logic [2:0]      new_edge_mask;
    logic [CntW-1:0] edges_total;
    logic            overflow;
    logic            last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture input word, reset per-item results
    logic       clear;     // empty the table
    logic       scan_rst;  // start search of current edge at entry 0
    logic       scan_step; // compare read data, advance address
    logic       commit;    // resolve edge: record match, insert or overflow
    logic [1:0] edge_sel;  // which edge of the triangle
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;   // registered read data matches current key
    logic at_end; // search has covered all stored entries
  } sts_t;

endpackage

// ===== hdl/ten_ctrl.sv =====
// Controller state machine for the triangle edge numbering block.
module ten_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          opcode_i,
  input  ten_pkg::sts_t sts_i,
  output ten_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);
  import ten_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] edge_q, edge_d;

  always_comb begin
    state_d = state_q;
    edge_d  = edge_q;
    ctl_o   = '0;
    ctl_o.edge_sel = edge_q;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          if (opcode_i == OP_CLEAR) begin
            ctl_o.clear = 1'b1;
            state_d = S_DONE;
          end else begin
            edge_d  = 2'd0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        ctl_o.scan_rst = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // read data for the current address is already registered in rd_q here
        if (sts_i.hit || sts_i.at_end) begin
          ctl_o.commit = 1'b1;
          if (edge_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            edge_d  = edge_q + 2'd1;
            state_d = S_INIT;
          end
        end else begin
          ctl_o.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      edge_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      edge_q  <= edge_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE) else $error("done not followed by idle");
  a_edge_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_q != 2'd3) else $error("edge select out of range");
`endif
endmodule

// ===== hdl/ten_dpath.sv =====
// Datapath for the triangle edge numbering block: key table and result.
module ten_dpath #(
  parameter int unsigned NodeBits = ten_pkg::NodeBitsDef,
  parameter int unsigned MaxEdges = ten_pkg::MaxEdgesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ten_pkg::in_word_t in_i,
  input  ten_pkg::ctl_t     ctl_i,
  input  logic              done_i,
  output ten_pkg::sts_t     sts_o,
  output ten_pkg::out_word_t out_o,
  output logic              strobe_o
);
  import ten_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxEdges);
  localparam int unsigned CW    = $clog2(MaxEdges + 1);
  localparam int unsigned KeyW  = 2 * NodeBits;

  logic [KeyW-1:0]     mem_q [MaxEdges];
  logic [KeyW-1:0]     rd_q;
  logic [NodeBits-1:0] na_q, nb_q, nc_q;
  logic                last_q;
  logic [CW-1:0]       cnt_q, addr_q;
  logic                rd_vld_q;
  logic [NumW-1:0]     num_q [3];
  logic [2:0]          mask_q;
  logic                ovf_q;
  logic [NodeBits-1:0] p, q, lo, hi;
  logic [KeyW-1:0]     key;
  logic                hit, at_end, full;

  always_comb begin
    case (ctl_i.edge_sel)
      2'd0:    begin p = na_q; q = nb_q; end
      2'd1:    begin p = nb_q; q = nc_q; end
      default: begin p = nc_q; q = na_q; end
    endcase
    lo  = (p < q) ? p : q;
    hi  = (p < q) ? q : p;
    key = {lo, hi};
  end

  // addr_q is the entry whose data sits in rd_q once rd_vld_q is set
  assign hit    = rd_vld_q && (rd_q == key);
  assign at_end = !rd_vld_q;
  assign full   = (cnt_q == CW'(MaxEdges));
  assign sts_o.hit    = hit;
  assign sts_o.at_end = at_end;

  // next read address: start of scan reads 0, step reads addr+1
  logic [CW-1:0] ra;
  always_comb begin
    ra = ctl_i.scan_rst ? '0 : addr_q + CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      na_q   <= NodeBits'(in_i.node_a);
      nb_q   <= NodeBits'(in_i.node_b);
      nc_q   <= NodeBits'(in_i.node_c);
      last_q <= in_i.last_triangle;
    end
    if (ctl_i.scan_rst || ctl_i.scan_step) begin
      rd_q <= mem_q[ra[AddrW-1:0]];
    end
    if (ctl_i.commit && !hit && !full) begin
      mem_q[cnt_q[AddrW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      mask_q   <= '0;
      ovf_q    <= 1'b0;
      num_q[0] <= '0;
      num_q[1] <= '0;
      num_q[2] <= '0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= done_i;
      if (ctl_i.load) begin
        mask_q   <= '0;
        ovf_q    <= 1'b0;
        num_q[0] <= '0;
        num_q[1] <= '0;
        num_q[2] <= '0;
      end
      if (ctl_i.clear) cnt_q <= '0;
      if (ctl_i.scan_rst || ctl_i.scan_step) begin
        addr_q   <= ra;
        rd_vld_q <= (ra < cnt_q);
      end
      if (ctl_i.commit) begin
        rd_vld_q <= 1'b0;
        if (hit) begin
          num_q[ctl_i.edge_sel] <= NumW'(addr_q);
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          num_q[ctl_i.edge_sel]  <= NumW'(cnt_q);
          mask_q[ctl_i.edge_sel] <= 1'b1;
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    out_o.edge_opposite_a = num_q[1];
    out_o.edge_opposite_b = num_q[2];
    out_o.edge_opposite_c = num_q[0];
    out_o.new_edge_mask   = mask_q;
    out_o.edges_total     = CntW'(cnt_q);
    out_o.overflow        = ovf_q;
    out_o.last            = last_q;
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxEdges)) else $error("edge count above table size");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.clear && !(ctl_i.commit && !hit && !full) |=> $stable(cnt_q))
    else $error("edge count changed without insert");
  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit && !hit && full |=> ovf_q) else $error("overflow flag not set");
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> addr_q < cnt_q) else $error("hit beyond stored entries");
`endif
endmodule

// ===== hdl/triangle_edge_numbering.sv =====
// Top level of the triangle edge numbering block.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------
//  input   | start_i, busy_o     | in_i  (ten_pkg::in_word_t)
//  result  | strobe_o (1 cycle)  | out_o (ten_pkg::out_word_t)
//
// A word is taken when start_i is high and busy_o low. A clear word goes
// straight to S_DONE, whose done pulse is registered into strobe_o. For a
// triangle, each edge (a-b, b-c, c-a) is a linear search through the
// single-port key memory, one entry per cycle, ending on a match or at the
// stored count. Reset is asynchronous and empties the table at once (the
// count goes to zero; no clearing pass). The receiver cannot stall; busy_o
// drops in the strobe cycle, so the next word can be taken at its end.
module triangle_edge_numbering #(
  parameter int unsigned NodeBits = ten_pkg::NodeBitsDef,
  parameter int unsigned MaxEdges = ten_pkg::MaxEdgesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ten_pkg::in_word_t  in_i,
  output logic               busy_o,
  output logic               strobe_o,
  output ten_pkg::out_word_t out_o
);
  import ten_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic done;

  ten_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (in_i.opcode),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy_o),
    .done_o   (done)
  );

  ten_dpath #(
    .NodeBits (NodeBits),
    .MaxEdges (MaxEdges)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .ctl_i    (ctl),
    .done_i   (done),
    .sts_o    (sts),
    .out_o    (out_o),
    .strobe_o (strobe_o)
  );

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !$past(strobe_o)) else $error("strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted word did not set busy");
  a_strobe_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy_o)) else $error("strobe without work");
`endif
endmodule

// ===== sim/tb_triangle_edge_numbering.sv =====
// Testbench for triangle_edge_numbering: directed table, table-full fill, random mesh strips.
module tb_triangle_edge_numbering;
  import ten_pkg::*;

  localparam int unsigned TblDepth  = MaxEdgesDef;
  localparam longint      CycLimit  = 40_000_000;
  localparam int          NumRandom = 40;
  localparam int unsigned PendDepth = 4;
  localparam int unsigned DirRows   = 13;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_word_t  in_i;
  logic      busy_o;
  logic      strobe_o;
  out_word_t out_o;

  triangle_edge_numbering dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .strobe_o(strobe_o),
    .out_o   (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Edge table predictor: own copy of the stored keys and count.
  // ---------------------------------------------------------------------
  logic [31:0] known_keys [TblDepth];
  int unsigned known_count;
  out_word_t   pend_words [PendDepth];
  int unsigned pend_wr, pend_rd;
  int unsigned n_errors;

  // Find or insert one undirected edge; returns its number.
  function automatic logic [NumW-1:0] number_edge(input logic [15:0] p, input logic [15:0] q,
                                                  output logic fresh, inout logic ovf);
    logic [31:0] key;
    key   = (p < q) ? {p, q} : {q, p};
    fresh = 1'b0;
    for (int i = 0; i < known_count; i++)
      if (known_keys[i] == key) return NumW'(i);
    if (known_count >= TblDepth) begin
      ovf = 1'b1;
      return '0;
    end
    known_keys[known_count] = key;
    fresh = 1'b1;
    known_count++;
    return NumW'(known_count - 1);
  endfunction

  function automatic out_word_t number_triangle(input in_word_t w);
    out_word_t r;
    logic [NumW-1:0] n_ab, n_bc, n_ca;
    logic f0, f1, f2, ovf;
    r   = '0;
    ovf = 1'b0;
    if (op_e'(w.opcode) == OP_CLEAR) begin
      known_count = 0;
    end else begin
      // order matters: a-b, then b-c, then c-a
      n_ab = number_edge(w.node_a, w.node_b, f0, ovf);
      n_bc = number_edge(w.node_b, w.node_c, f1, ovf);
      n_ca = number_edge(w.node_c, w.node_a, f2, ovf);
      r.edge_opposite_a = n_bc;
      r.edge_opposite_b = n_ca;
      r.edge_opposite_c = n_ab;
      r.new_edge_mask   = {f2, f1, f0};
      r.overflow        = ovf;
    end
    r.edges_total = CntW'(known_count);
    r.last        = w.last_triangle;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: no backpressure, so every strobe is one word.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pend_rd == pend_wr) begin
        report_mismatch("result word with nothing pending");
      end else begin
        out_word_t e;
        e = pend_words[pend_rd % PendDepth];
        pend_rd++;
        if (out_o.edge_opposite_a !== e.edge_opposite_a)
          report_mismatch($sformatf("opp_a %0d exp %0d", out_o.edge_opposite_a,
                                    e.edge_opposite_a));
        if (out_o.edge_opposite_b !== e.edge_opposite_b)
          report_mismatch($sformatf("opp_b %0d exp %0d", out_o.edge_opposite_b,
                                    e.edge_opposite_b));
        if (out_o.edge_opposite_c !== e.edge_opposite_c)
          report_mismatch($sformatf("opp_c %0d exp %0d", out_o.edge_opposite_c,
                                    e.edge_opposite_c));
        if (out_o.new_edge_mask !== e.new_edge_mask)
          report_mismatch($sformatf("mask %b exp %b", out_o.new_edge_mask, e.new_edge_mask));
        if (out_o.edges_total !== e.edges_total)
          report_mismatch($sformatf("total %0d exp %0d", out_o.edges_total, e.edges_total));
        if (out_o.overflow !== e.overflow)
          report_mismatch($sformatf("overflow %b exp %b", out_o.overflow, e.overflow));
        if (out_o.last !== e.last)
          report_mismatch($sformatf("last %b exp %b", out_o.last, e.last));
      end
    end
  end

  // Watchdog
  longint cyc_count;
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > CycLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  int unsigned idle_mode; // 0: no gaps, 1: short gaps, 2: mixed with long ones

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (r < 55) return 0;
    if (r < 92 || idle_mode == 1) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word, hold it until taken, record the prediction, then idle for any drawn gap.
  // chk: compare against the typed expectation as well.
  task automatic send_word(input in_word_t w, input bit chk, input out_word_t typed);
    out_word_t p;
    int unsigned g;
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    p = number_triangle(w);
    if (chk && p !== typed)
      report_mismatch($sformatf("predictor disagrees with typed row %h", w));
    pend_words[pend_wr % PendDepth] = chk ? typed : p;
    pend_wr++;
    g = draw_gap();
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic in_word_t mk(input op_e op, input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c, input logic lt);
    in_word_t w;
    w.opcode        = op;
    w.node_a        = a;
    w.node_b        = b;
    w.node_c        = c;
    w.last_triangle = lt;
    return w;
  endfunction

  function automatic out_word_t rs(input int oa, input int ob, input int oc, input int m,
                                   input int tot, input logic ov, input logic lt);
    out_word_t r;
    r.edge_opposite_a = NumW'(oa);
    r.edge_opposite_b = NumW'(ob);
    r.edge_opposite_c = NumW'(oc);
    r.new_edge_mask   = 3'(m);
    r.edges_total     = CntW'(tot);
    r.overflow        = ov;
    r.last            = lt;
    return r;
  endfunction

  typedef struct {
    in_word_t  w;
    bit        chk;
    out_word_t r;
  } stim_row_t;

  stim_row_t dir_rows [DirRows];

  initial begin
    logic [15:0] base;
    in_word_t    w;
    start_i     = 1'b0;
    in_i        = '0;
    rst_ni      = 1'b0;
    cyc_count   = 0;
    n_errors    = 0;
    known_count = 0;
    pend_wr     = 0;
    pend_rd     = 0;
    idle_mode   = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear after reset, degenerate triangles, node extremes, shared edges.
    dir_rows[0]  = '{mk(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b1), 1, rs(0, 0, 0, 0, 0, 0, 1)};
    dir_rows[1]  = '{mk(OP_ADD, 16'h0, 16'h0, 16'h0, 1'b0), 1, rs(0, 0, 0, 1, 1, 0, 0)};
    dir_rows[2]  = '{mk(OP_ADD, 16'hFFFF, 16'hFFFF, 16'h0, 1'b1), 1,
                     rs(2, 2, 1, 3, 3, 0, 1)};
    dir_rows[3]  = '{mk(OP_ADD, 16'h0, 16'hFFFF, 16'h0, 1'b0), 1, rs(2, 0, 2, 0, 3, 0, 0)};
    dir_rows[4]  = '{mk(OP_ADD, 16'h0001, 16'h0002, 16'h0003, 1'b0), 0, '0};
    dir_rows[5]  = '{mk(OP_ADD, 16'h0003, 16'h0002, 16'h0004, 1'b0), 0, '0};
    dir_rows[6]  = '{mk(OP_ADD, 16'h0004, 16'h0001, 16'h0003, 1'b0), 0, '0};
    dir_rows[7]  = '{mk(OP_ADD, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1), 0, '0};
    dir_rows[8]  = '{mk(OP_ADD, 16'h5555, 16'hAAAA, 16'h8000, 1'b0), 0, '0};
    dir_rows[9]  = '{mk(OP_ADD, 16'h7FFF, 16'h8000, 16'hFFFE, 1'b0), 0, '0};
    dir_rows[10] = '{mk(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0), 1,
                     rs(0, 0, 0, 0, 0, 0, 0)};
    // after a clear, numbering restarts from zero
    dir_rows[11] = '{mk(OP_ADD, 16'h0001, 16'h0002, 16'h0003, 1'b1), 1,
                     rs(1, 2, 0, 7, 3, 0, 1)};
    dir_rows[12] = '{mk(OP_ADD, 16'h0002, 16'h0001, 16'h0003, 1'b0), 1,
                     rs(2, 1, 0, 0, 3, 0, 0)};
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].r);

    // Table full: disjoint triangles until the table overflows, no gaps (this is slow).
    idle_mode = 0;
    send_word(mk(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b0), 0, '0);
    for (int k = 0; k < (TblDepth + 2) / 3 + 1; k++)
      send_word(mk(OP_ADD, 16'(3 * k), 16'(3 * k + 1), 16'(3 * k + 2), 1'b0), 0, '0);
    idle_mode = 2;
    // an old edge still resolves; new ones (even repeated) overflow
    send_word(mk(OP_ADD, 16'h0000, 16'h0001, 16'hF000, 1'b1), 0, '0);
    send_word(mk(OP_ADD, 16'hF000, 16'hF001, 16'hF000, 1'b0), 0, '0);
    send_word(mk(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b1), 1, rs(0, 0, 0, 0, 0, 0, 1));

    // Random: mesh strips around a random base so edges are shared, with
    // a sprinkle of fully random triangles and regular clears to keep searches short.
    base = 16'($urandom());
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 10 == 0) idle_mode = $urandom_range(0, 2);
      if (known_count > 60 || $urandom_range(0, 29) == 0) begin
        w = mk(OP_CLEAR, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
        base = 16'($urandom());
      end else if ($urandom_range(0, 9) == 0) begin
        w = mk(OP_ADD, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
      end else begin
        w = mk(OP_ADD, base + 16'($urandom_range(0, 7)), base + 16'($urandom_range(0, 7)),
               base + 16'($urandom_range(0, 7)), 1'($urandom_range(0, 9) == 0));
      end
      send_word(w, 0, '0);
    end
    start_i <= 1'b0;

    while (pend_rd != pend_wr) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
